@@ rtl/set_assoc_cache_nru_lookup_core_defines.svh @@
// Assertion helpers shared by the lookup core.
`ifndef SET_ASSOC_CACHE_NRU_LOOKUP_CORE_DEFINES_SVH
`define SET_ASSOC_CACHE_NRU_LOOKUP_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define SACN_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define SACN_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/sacn_pkg.sv @@
`default_nettype none
package sacn_pkg;

    localparam int ADDR_BITS    = 16;
    localparam int MAX_SETS     = 256;
    localparam int SET_W        = 8;
    localparam int MAX_WAYS     = 8;
    localparam int WAY_W        = 3;
    localparam int TAG_W        = 16;
    localparam int MISS_W       = 16;
    localparam int CFG_W        = 4;
    localparam int CFG_IDX_W    = 2;
    localparam int OUT_DATA_W   = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE = 2'd2;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_LOOKUP
    } t_state;

    // one set of the cache: tags, valid and NRU bits of every way
    typedef struct packed {
        logic [MAX_WAYS-1:0][TAG_W-1:0] tag;
        logic [MAX_WAYS-1:0]            valid;
        logic [MAX_WAYS-1:0]            nru;
    } t_row;

    typedef struct packed {
        logic load;    // take the address, read the set
        logic update;  // write the set back, fill the result register
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

@@ rtl/sacn_ctrl.sv @@
`default_nettype none
module sacn_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire sacn_pkg::t_sts i_sts,
    output sacn_pkg::t_cmd     o_cmd,
    output logic               o_in_ready
);

    sacn_pkg::t_state r_state;
    sacn_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sacn_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_cmd.load   = 1'b0;
        o_cmd.update = 1'b0;
        o_in_ready   = 1'b0;
        case (r_state)
            sacn_pkg::ST_IDLE: begin
                // nothing is taken while reset is held
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    o_cmd.load = 1'b1;
                    n_state    = sacn_pkg::ST_LOOKUP;
                end
            end
            sacn_pkg::ST_LOOKUP: begin
                // hold the set read until the result register can take the result
                if (i_sts.out_free) begin
                    o_cmd.update = 1'b1;
                    n_state      = sacn_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = sacn_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

@@ rtl/sacn_datapath.sv @@
`default_nettype none
module sacn_datapath (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire sacn_pkg::t_cmd                        i_cmd,
    output sacn_pkg::t_sts                             o_sts,
    input  wire logic [sacn_pkg::ADDR_BITS-1:0]        i_address,
    input  wire logic                                  i_cfg_we,
    input  wire logic [sacn_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [sacn_pkg::CFG_W-1:0]            i_cfg_data,
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_ready,
    output logic [sacn_pkg::OUT_DATA_W-1:0]            o_out_data
);

    logic [sacn_pkg::CFG_W-1:0] r_offset_bits;
    logic [sacn_pkg::CFG_W-1:0] r_index_bits;
    logic [sacn_pkg::CFG_W-1:0] r_ways_in_use;

    sacn_pkg::t_row r_mem [sacn_pkg::MAX_SETS];
    logic [sacn_pkg::MAX_SETS-1:0] r_row_init;

    sacn_pkg::t_row r_rd_row;
    logic r_rd_init;
    logic [sacn_pkg::SET_W-1:0] r_set;
    logic [sacn_pkg::TAG_W-1:0] r_tag;
    logic [sacn_pkg::MISS_W-1:0] r_miss;
    logic [sacn_pkg::MISS_W-1:0] n_miss;
    logic r_out_valid;
    logic [sacn_pkg::OUT_DATA_W-1:0] r_out_data;

    logic [sacn_pkg::CFG_W-1:0] ib;
    logic [sacn_pkg::CFG_W:0] shift;
    logic [sacn_pkg::SET_W:0] set_mask;
    logic [sacn_pkg::ADDR_BITS-1:0] addr_sh;
    logic [sacn_pkg::ADDR_BITS-1:0] tag_full;
    logic [sacn_pkg::SET_W-1:0] set_in;

    logic [sacn_pkg::CFG_W-1:0] ways_eff;
    logic [sacn_pkg::MAX_WAYS-1:0] en;
    logic [sacn_pkg::MAX_WAYS-1:0] cur_valid;
    logic [sacn_pkg::MAX_WAYS-1:0] cur_nru;
    logic [sacn_pkg::MAX_WAYS-1:0] hit_vec;
    logic [sacn_pkg::MAX_WAYS-1:0] inv_vec;
    logic [sacn_pkg::MAX_WAYS-1:0] nru_vec;
    logic [sacn_pkg::WAY_W-1:0] hit_way;
    logic [sacn_pkg::WAY_W-1:0] inv_way;
    logic [sacn_pkg::WAY_W-1:0] nru_way;
    logic hit;
    logic [sacn_pkg::WAY_W-1:0] way;
    sacn_pkg::t_row n_row;

    // address split; index count saturates at the set address width
    always_comb begin
        ib       = (r_index_bits > sacn_pkg::CFG_W'(sacn_pkg::SET_W))
                 ? sacn_pkg::CFG_W'(sacn_pkg::SET_W) : r_index_bits;
        shift    = {1'b0, r_offset_bits} + {1'b0, ib};
        set_mask = (9'd1 << ib) - 9'd1;
        addr_sh  = i_address >> r_offset_bits;
        set_in   = addr_sh[sacn_pkg::SET_W-1:0] & set_mask[sacn_pkg::SET_W-1:0];
        tag_full = i_address >> shift;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rd_row <= r_mem[set_in];
            r_rd_init <= r_row_init[set_in];
            r_set <= set_in;
            r_tag <= tag_full[sacn_pkg::TAG_W-1:0];
        end
        if (i_cmd.update) begin
            r_mem[r_set] <= n_row;
        end
    end

    // way search and replacement
    always_comb begin
        if (r_ways_in_use == '0) begin
            ways_eff = sacn_pkg::CFG_W'(1);
        end else if (r_ways_in_use > sacn_pkg::CFG_W'(sacn_pkg::MAX_WAYS)) begin
            ways_eff = sacn_pkg::CFG_W'(sacn_pkg::MAX_WAYS);
        end else begin
            ways_eff = r_ways_in_use;
        end
        // a set never written reads as empty with all NRU bits set
        cur_valid = r_rd_init ? r_rd_row.valid : '0;
        cur_nru   = r_rd_init ? r_rd_row.nru : '1;
        for (int i = 0; i < sacn_pkg::MAX_WAYS; i++) begin
            en[i]      = sacn_pkg::CFG_W'(i) < ways_eff;
            hit_vec[i] = en[i] && cur_valid[i] && (r_rd_row.tag[i] == r_tag);
            inv_vec[i] = en[i] && !cur_valid[i];
            nru_vec[i] = en[i] && cur_nru[i];
        end
        hit_way = '0;
        inv_way = '0;
        nru_way = '0;
        for (int i = sacn_pkg::MAX_WAYS - 1; i >= 0; i--) begin
            if (hit_vec[i]) hit_way = sacn_pkg::WAY_W'(i);
            if (inv_vec[i]) inv_way = sacn_pkg::WAY_W'(i);
            if (nru_vec[i]) nru_way = sacn_pkg::WAY_W'(i);
        end
        hit = |hit_vec;

        n_row.tag   = r_rd_row.tag;
        n_row.valid = cur_valid;
        n_row.nru   = cur_nru;
        if (hit) begin
            way = hit_way;
        end else if (|inv_vec) begin
            way = inv_way;
        end else if (|nru_vec) begin
            way = nru_way;
        end else begin
            way = '0;
            n_row.nru = cur_nru | en;
        end
        if (!hit) begin
            n_row.tag[way]   = r_tag;
            n_row.valid[way] = 1'b1;
        end
        n_row.nru[way] = 1'b0;

        n_miss = r_miss;
        if (!hit && (r_miss != '1)) begin
            n_miss = r_miss + sacn_pkg::MISS_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset_bits <= '0;
            r_index_bits  <= '0;
            r_ways_in_use <= sacn_pkg::CFG_W'(1);
            r_row_init    <= '0;
            r_miss        <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    sacn_pkg::CFG_OFFSET_BITS: r_offset_bits <= i_cfg_data;
                    sacn_pkg::CFG_INDEX_BITS:  r_index_bits  <= i_cfg_data;
                    sacn_pkg::CFG_WAYS_IN_USE: r_ways_in_use <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.update) begin
                r_row_init[r_set] <= 1'b1;
                r_miss            <= n_miss;
                r_out_valid       <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_out_data <= {4'b0, n_miss, r_set, way, hit};
        end
    end

    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_out_data     = r_out_data;

endmodule
`default_nettype wire

@@ rtl/set_assoc_cache_nru_lookup_core.sv @@
// Channel   | Direction | Payload
// s_axis    | in        | tdata[15:0] address
// m_axis    | out       | tdata[0] hit, [3:1] way_used, [11:4] set_index, [27:12] miss_total
// cfg       | in        | index 0 offset_bits, 1 index_bits, 2 ways_in_use; data[3:0]
//
// Each address goes through a set row read (registered), then compare and write back.
// The single-port set memory (one row per set) allows one address in flight at a time.
// Synchronous active-low reset; sets read as empty until first written, no clearing pass.
// A full, unclaimed result register holds the compare and write back; one new address is still taken.
`default_nettype none
`include "set_assoc_cache_nru_lookup_core_defines.svh"
module set_assoc_cache_nru_lookup_core (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_s_axis_tvalid,
    output logic                                     o_s_axis_tready,
    input  wire logic [sacn_pkg::ADDR_BITS-1:0]      i_s_axis_tdata,  // [15:0] address
    output logic                                     o_m_axis_tvalid,
    input  wire logic                                i_m_axis_tready,
    // [0] hit, [3:1] way_used, [11:4] set_index, [27:12] miss_total, [31:28] zero
    output logic [sacn_pkg::OUT_DATA_W-1:0]          o_m_axis_tdata,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [sacn_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [sacn_pkg::CFG_W-1:0]          i_cfg_data
);

    sacn_pkg::t_cmd cmd;
    sacn_pkg::t_sts sts;

    assign o_cfg_ready = i_rst_n;

    sacn_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_ready (o_s_axis_tready)
    );

    sacn_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_address   (i_s_axis_tdata),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out_data  (o_m_axis_tdata)
    );

    `SACN_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n,
        i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready,
        "input taken while a lookup is in flight")
    `SACN_ASSERT_NOW(a_update_slot_free, i_clk, i_rst_n,
        cmd.update, !o_m_axis_tvalid || i_m_axis_tready,
        "result written over an unclaimed result")
    `SACN_ASSERT_NOW(a_no_load_on_update, i_clk, i_rst_n,
        cmd.update, !cmd.load,
        "set read and write back in the same cycle")
    `SACN_ASSERT_NEXT(a_result_follows_update, i_clk, i_rst_n,
        cmd.update, o_m_axis_tvalid,
        "write back without a result")

endmodule
`default_nettype wire

@@ verif/tb_set_assoc_cache_nru_lookup_core.sv @@
`default_nettype none
module tb_set_assoc_cache_nru_lookup_core;
    import sacn_pkg::*;

    localparam int STALL_LIMIT = 1000;
    localparam int HOLD_CYCLES = 60;
    localparam int N_DIR       = 29;
    localparam int N_PHASES    = 6;
    localparam int PHASE_ITEMS = 68;

    typedef struct packed {
        logic             hit;
        logic [WAY_W-1:0] way;
        logic [SET_W-1:0] set_idx;
        logic [MISS_W-1:0] misses;
    } t_cache_result;

    typedef enum logic {ROW_ADDR, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind            kind;
        logic [CFG_IDX_W-1:0] reg_sel;
        logic [CFG_W-1:0]     reg_val;
        logic [ADDR_BITS-1:0] addr;
        logic                 typed;
        t_cache_result        given;
    } t_dir_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [ADDR_BITS-1:0]  i_s_axis_tdata = '0;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_W-1:0]      i_cfg_data = '0;

    set_assoc_cache_nru_lookup_core u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // shadow copy of the cache state
    logic [TAG_W-1:0]  tag_mem   [MAX_SETS*MAX_WAYS];
    bit                valid_mem [MAX_SETS*MAX_WAYS];
    bit                nru_mem   [MAX_SETS*MAX_WAYS];
    logic [MISS_W-1:0] miss_cnt;
    logic [CFG_W-1:0]  cfg_offset_bits;
    logic [CFG_W-1:0]  cfg_index_bits;
    logic [CFG_W-1:0]  cfg_ways;

    t_cache_result expected_lookups[$];
    int            mismatch_count = 0;
    bit            hold_req = 1'b0;
    bit            quiet = 1'b0;
    int            stall_cycles = 0;
    t_dir_row      dir_rows [N_DIR];

    function automatic t_cache_result nru_lookup(input logic [ADDR_BITS-1:0] addr);
        int            ib;
        int            nw;
        int            sh;
        int            base;
        int            w;
        logic [31:0]   set_no;
        logic [TAG_W-1:0] tag;
        bit            found;
        t_cache_result r;
        ib = (cfg_index_bits > SET_W) ? SET_W : int'(cfg_index_bits);
        nw = (cfg_ways == 0) ? 1 : (cfg_ways > MAX_WAYS) ? MAX_WAYS : int'(cfg_ways);
        sh = int'(cfg_offset_bits) + ib;
        set_no = ({16'd0, addr} >> cfg_offset_bits) & ((32'd1 << ib) - 32'd1);
        tag = (sh >= ADDR_BITS) ? '0 : TAG_W'(addr >> sh);
        base = int'(set_no) * MAX_WAYS;
        found = 1'b0;
        w = 0;
        // lowest matching way wins when a tag sits in several ways
        for (int i = 0; i < nw; i++) begin
            if (!found && valid_mem[base+i] && tag_mem[base+i] == tag) begin
                found = 1'b1;
                w = i;
            end
        end
        r.hit = found;
        if (found) begin
            nru_mem[base+w] = 1'b0;
        end else begin
            if (miss_cnt != '1) miss_cnt++;
            for (int i = 0; i < nw; i++) begin
                if (!found && !valid_mem[base+i]) begin
                    found = 1'b1;
                    w = i;
                end
            end
            for (int i = 0; i < nw; i++) begin
                if (!found && nru_mem[base+i]) begin
                    found = 1'b1;
                    w = i;
                end
            end
            if (!found) begin
                for (int i = 0; i < nw; i++) nru_mem[base+i] = 1'b1;
                w = 0;
            end
            tag_mem[base+w]   = tag;
            valid_mem[base+w] = 1'b1;
            nru_mem[base+w]   = 1'b0;
        end
        r.way     = WAY_W'(w);
        r.set_idx = set_no[SET_W-1:0];
        r.misses  = miss_cnt;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < 30)
            $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
        mismatch_count++;
    endtask

    // called at a falling edge, returns at a falling edge
    task automatic push_addr(input logic [ADDR_BITS-1:0] a, input logic typed,
                             input t_cache_result given);
        t_cache_result predicted;
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata  = a;
        do @(posedge i_clk); while (!o_s_axis_tready);
        predicted = nru_lookup(a);
        expected_lookups = {expected_lookups, (typed ? given : predicted)};
        @(negedge i_clk);
    endtask

    task automatic sender_gap();
        if (!quiet && $urandom_range(0, 5) == 0) begin
            i_s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge i_clk);
        end
    endtask

    task automatic wait_drained();
        i_s_axis_tvalid = 1'b0;
        while (expected_lookups.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] sel, input logic [CFG_W-1:0] val);
        wait_drained();
        i_cfg_valid = 1'b1;
        i_cfg_index = sel;
        i_cfg_data  = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (sel)
            CFG_OFFSET_BITS: cfg_offset_bits = val;
            CFG_INDEX_BITS:  cfg_index_bits  = val;
            CFG_WAYS_IN_USE: cfg_ways        = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // receiver: random stall bursts, one long hold-off on request
    initial begin
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_req = 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                i_m_axis_tready = 1'b0;
                repeat ($urandom_range(1, 13) - 1) @(negedge i_clk);
            end else begin
                i_m_axis_tready = 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_cache_result got;
        t_cache_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.hit     = o_m_axis_tdata[0];
            got.way     = o_m_axis_tdata[3:1];
            got.set_idx = o_m_axis_tdata[11:4];
            got.misses  = o_m_axis_tdata[27:12];
            if (expected_lookups.size() == 0) begin
                report_mismatch("unexpected result", o_m_axis_tdata, '0);
            end else begin
                want = expected_lookups.pop_front();
                if (got.hit !== want.hit)
                    report_mismatch("hit", 32'(got.hit), 32'(want.hit));
                if (got.way !== want.way)
                    report_mismatch("way_used", 32'(got.way), 32'(want.way));
                if (got.set_idx !== want.set_idx)
                    report_mismatch("set_index", 32'(got.set_idx), 32'(want.set_idx));
                if (got.misses !== want.misses)
                    report_mismatch("miss_total", 32'(got.misses), 32'(want.misses));
            end
        end
    end

    // watchdog: cycles without any transaction
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        int          ib;
        int          sh;
        int          hot_set;
        int          tail;
        logic [31:0] a32;
        logic [ADDR_BITS-1:0] a;

        for (int i = 0; i < MAX_SETS*MAX_WAYS; i++) begin
            valid_mem[i] = 1'b0;
            nru_mem[i]   = 1'b1;
        end
        miss_cnt        = '0;
        cfg_offset_bits = '0;
        cfg_index_bits  = '0;
        cfg_ways        = 4'd1;

        dir_rows = '{
            // one way, no index: address is the tag
            '{ROW_ADDR, CFG_OFFSET_BITS, 4'd0, 16'h0000, 1'b1, '{1'b0, 3'd0, 8'd0, 16'd1}},
            '{ROW_ADDR, CFG_OFFSET_BITS, 4'd0, 16'h0000, 1'b1, '{1'b1, 3'd0, 8'd0, 16'd1}},
            '{ROW_ADDR, CFG_OFFSET_BITS, 4'd0, 16'hFFFF, 1'b1, '{1'b0, 3'd0, 8'd0, 16'd2}},
            '{ROW_ADDR, CFG_OFFSET_BITS, 4'd0, 16'hFFFF, 1'b1, '{1'b1, 3'd0, 8'd0, 16'd2}},
            // offset and index past the address width, index and ways saturate
            '{ROW_CFG,  CFG_OFFSET_BITS, 4'd15, 16'h0000, 1'b0, '0},
            '{ROW_CFG,  CFG_INDEX_BITS,  4'd15, 16'h0000, 1'b0, '0},
            '{ROW_CFG,  CFG_WAYS_IN_USE, 4'd15, 16'h0000, 1'b0, '0},
            '{ROW_ADDR, CFG_OFFSET_BITS, 4'd0, 16'h8000, 1'b1, '{1'b0, 3'd0, 8'd1, 16'd3}},
            '{ROW_ADDR, CFG_OFFSET_BITS, 4'd0, 16'h7FFF, 1'b0, '0},
            '{ROW_ADDR, CFG_OFFSET_BITS, 4'd0, 16'h0000, 1'b0, '0},
            '{ROW_CFG,  CFG_OFFSET_BITS, 4'd0, 16'h0000, 1'b0, '0},
            '{ROW_CFG,  CFG_INDEX_BITS,  4'd8, 16'h0000, 1'b0, '0},
            '{ROW_CFG,  CFG_WAYS_IN_USE, 4'd8, 16'h0000, 1'b0, '0},
            // nine tags into one set: fill, then NRU wraps to way 0
            '{ROW_ADDR, CFG_OFFSET_BITS, 4'd0, 16'h0012, 1'b0, '0},
            '{ROW_ADDR, CFG_OFFSET_BITS, 4'd0, 16'h0112, 1'b0, '0},
            '{ROW_ADDR, CFG_OFFSET_BITS, 4'd0, 16'h0212, 1'b0, '0},
            '{ROW_ADDR, CFG_OFFSET_BITS, 4'd0, 16'h0312, 1'b0, '0},
            '{ROW_ADDR, CFG_OFFSET_BITS, 4'd0, 16'h0412, 1'b0, '0},
            '{ROW_ADDR, CFG_OFFSET_BITS, 4'd0, 16'h0512, 1'b0, '0},
            '{ROW_ADDR, CFG_OFFSET_BITS, 4'd0, 16'h0612, 1'b0, '0},
            '{ROW_ADDR, CFG_OFFSET_BITS, 4'd0, 16'h0712, 1'b0, '0},
            '{ROW_ADDR, CFG_OFFSET_BITS, 4'd0, 16'h0812, 1'b0, '0},
            '{ROW_ADDR, CFG_OFFSET_BITS, 4'd0, 16'h0112, 1'b0, '0},
            '{ROW_ADDR, CFG_OFFSET_BITS, 4'd0, 16'h0912, 1'b0, '0},
            // zero ways acts as one; leaves the same tag in two ways
            '{ROW_CFG,  CFG_WAYS_IN_USE, 4'd0, 16'h0000, 1'b0, '0},
            '{ROW_ADDR, CFG_OFFSET_BITS, 4'd0, 16'h0912, 1'b0, '0},
            '{ROW_CFG,  CFG_WAYS_IN_USE, 4'd8, 16'h0000, 1'b0, '0},
            '{ROW_ADDR, CFG_OFFSET_BITS, 4'd0, 16'h0912, 1'b0, '0},
            '{ROW_ADDR, CFG_OFFSET_BITS, 4'd0, 16'h1234, 1'b0, '0}
        };

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        for (int r = 0; r < N_DIR; r++) begin
            if (dir_rows[r].kind == ROW_CFG) begin
                write_cfg(dir_rows[r].reg_sel, dir_rows[r].reg_val);
            end else begin
                sender_gap();
                push_addr(dir_rows[r].addr, dir_rows[r].typed, dir_rows[r].given);
            end
        end

        for (int p = 0; p < N_PHASES; p++) begin
            write_cfg(CFG_OFFSET_BITS, ($urandom_range(0, 4) == 0) ?
                      CFG_W'($urandom_range(0, 15)) : CFG_W'($urandom_range(0, 5)));
            write_cfg(CFG_INDEX_BITS, ($urandom_range(0, 3) == 0) ?
                      CFG_W'($urandom_range(0, 15)) : CFG_W'($urandom_range(0, 4)));
            write_cfg(CFG_WAYS_IN_USE, CFG_W'($urandom_range(0, 15)));
            ib = (cfg_index_bits > SET_W) ? SET_W : int'(cfg_index_bits);
            sh = int'(cfg_offset_bits) + ib;
            hot_set = $urandom_range(0, 255);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 1 && n == 20) hold_req = 1'b1;
                if (p == 2 && n == 30) wait_drained();
                if ($urandom_range(0, 9) < 7) begin
                    // small pool of tags over two neighboring sets
                    a32 = (32'($urandom_range(0, 9)) << sh)
                        | ((32'(hot_set + $urandom_range(0, 1)) & ((32'd1 << ib) - 1))
                           << cfg_offset_bits)
                        | ($urandom & ((32'd1 << cfg_offset_bits) - 1));
                end else begin
                    a32 = $urandom_range(0, 65535);
                end
                a = a32[ADDR_BITS-1:0];
                sender_gap();
                push_addr(a, 1'b0, '0);
            end
        end

        // last part: no idling on either side
        wait_drained();
        quiet = 1'b1;
        write_cfg(CFG_OFFSET_BITS, 4'd0);
        write_cfg(CFG_INDEX_BITS, 4'd0);
        write_cfg(CFG_WAYS_IN_USE, 4'd1);
        tail = 0;
        while (tail < 24) begin
            a = ($urandom_range(0, 1) == 0) ? 16'h8000 : 16'(3 * $urandom_range(0, 3));
            push_addr(a, 1'b0, '0);
            tail++;
        end
        i_s_axis_tvalid = 1'b0;

        while (expected_lookups.size() != 0) @(negedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
`default_nettype wire
